// ===== rtl/core/swm_pkg.sv =====
// Shared types and constants for the sliding window mean block.
package swm_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int SUM_BITS        = 22;
   localparam int MEAN_BITS       = 16;
   localparam int LEN_BITS        = 7;
   localparam int KEEP_BITS       = 6;
   localparam int COUNT_OUT_BITS  = 7;
   localparam int WINDOW_MAX_DEF  = 64;
   localparam int WINDOW_LEN_RST  = 64;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_TRIM  = 2'd2;

   typedef struct packed {
      logic [1:0]                    operation;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [KEEP_BITS-1:0]          keep_count;
   } req_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0]  window_sum;
      logic signed [MEAN_BITS-1:0] window_mean;
      logic [COUNT_OUT_BITS-1:0]   sample_count;
      logic                        window_full;
      logic                        window_empty;
   } rsp_type;

endpackage

// ===== rtl/core/sliding_window_mean.sv =====
// Sliding window mean: ring store of samples, running sum and iterative mean divider.
//
// The block holds the newest samples, at most window_length of them, in a ring
// memory of WINDOW_MAX entries and keeps their running sum in a register. Each
// request transfer adds a sample (dropping the oldest once the window is full),
// clears the window, or trims it to the newest keep_count samples; any other
// operation code leaves the window as it is. Each request produces exactly one
// response transfer with the sum, the mean (sum divided by count, truncated
// toward zero, 0 when empty), the count and the full and empty flags, all taken
// after the operation. req_stall is high while an item is in work, from the
// accepting edge until its response is loaded. An add that drops the oldest
// sample and a trim that drops samples do extra work per drop: each drop is a
// memory read followed by a subtract. The mean comes from a restoring divider
// that retires one quotient bit per cycle over the 22 sum bits; an item that
// leaves the window empty (a clear, a trim to zero, any item but an add on an
// empty window) skips the divider. The response is loaded at the edge that
// ends the stall, unless the previous one still waits for the far side, which
// stretches the stall. The response sits in its own register, so the next
// request is taken while a result waits for the far side. Writing csr_wdata
// through csr_we sets window_length and clears the window; do it only while no
// request is in work. A window_length of 0 acts as 1, any value above
// WINDOW_MAX acts as WINDOW_MAX. The sample memory needs no clearing pass: only
// values read from held positions are ever used.
module sliding_window_mean
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [LEN_BITS-1:0] csr_wdata
);

   localparam int PW       = $clog2(WINDOW_MAX);
   localparam int CW       = $clog2(WINDOW_MAX + 1);
   localparam int CMP_BITS = (CW > KEEP_BITS) ? CW : KEEP_BITS;
   localparam int LCMP     = (CW > LEN_BITS) ? CW : LEN_BITS;
   localparam int STEP_W   = $clog2(SUM_BITS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SUB,
      S_PREP,
      S_DIV,
      S_PUT
   } state_type;

   // Window state
   state_type                   state_ff, state_in;
   logic [PW-1:0]               oldest_ff, oldest_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [SUM_BITS-1:0]         sum_ff, sum_in;
   logic [LEN_BITS-1:0]         wlen_ff, wlen_in;

   // Latched request
   logic [1:0]                  op_ff, op_in;
   logic [SAMPLE_BITS-1:0]      smp_ff, smp_in;
   logic [KEEP_BITS-1:0]        keep_ff, keep_in;

   // Divider
   logic [CW-1:0]               rem_ff, rem_in;
   logic [SUM_BITS-1:0]         quo_ff, quo_in;
   logic                        neg_ff, neg_in;
   logic [STEP_W-1:0]           step_ff, step_in;

   // Response register
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_data_ff, rsp_data_in;

   // Sample memory
   logic [SAMPLE_BITS-1:0]      store_mem [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0]      rd_data_ff;
   logic                        mem_we;
   logic [PW-1:0]               mem_wa;
   logic [SAMPLE_BITS-1:0]      mem_wd;
   logic [PW-1:0]               mem_ra;

   // Helpers
   logic [CW-1:0]               len;
   logic [CW:0]                 wr_pos;
   logic [PW-1:0]               wr_addr;
   logic [PW-1:0]               oldest_next;
   logic [SUM_BITS-1:0]         old_ext;
   logic [SUM_BITS-1:0]         smp_ext;
   logic [SUM_BITS-1:0]         req_ext;
   logic [CW:0]                 trial;
   logic                        trial_ge;
   logic                        req_take;
   logic                        at_len;
   logic [CW-1:0]               count_dec;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Effective window length: zero acts as one, clamp to the memory depth
   always_comb begin
      if (wlen_ff == '0) begin
         len = CW'(1);
      end else if (LCMP'(wlen_ff) > LCMP'(WINDOW_MAX)) begin
         len = CW'(WINDOW_MAX);
      end else begin
         len = CW'(wlen_ff);
      end
   end

   // Slot just past the newest sample; oldest and count together stay below 2x depth
   always_comb begin
      wr_pos = {1'b0, CW'(oldest_ff)} + {1'b0, count_ff};
      if (wr_pos >= (CW+1)'(WINDOW_MAX)) begin
         wr_pos = wr_pos - (CW+1)'(WINDOW_MAX);
      end
      wr_addr = PW'(wr_pos);
   end

   assign oldest_next = (oldest_ff == PW'(WINDOW_MAX - 1)) ? '0 : oldest_ff + PW'(1);
   assign old_ext = {{(SUM_BITS-SAMPLE_BITS){rd_data_ff[SAMPLE_BITS-1]}}, rd_data_ff};
   assign smp_ext = {{(SUM_BITS-SAMPLE_BITS){smp_ff[SAMPLE_BITS-1]}}, smp_ff};
   assign req_ext = {{(SUM_BITS-SAMPLE_BITS){req_data.sample[SAMPLE_BITS-1]}},
                     req_data.sample};
   assign at_len    = (count_ff >= len);
   assign count_dec = count_ff - CW'(1);

   // One restoring division step
   assign trial    = {rem_ff, quo_ff[SUM_BITS-1]};
   assign trial_ge = (trial >= {1'b0, count_ff});

   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      wlen_in      = wlen_ff;
      op_in        = op_ff;
      smp_in       = smp_ff;
      keep_in      = keep_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = wr_addr;
      mem_wd       = req_data.sample;
      mem_ra       = oldest_ff;

      // Drop the response once the far side takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in   = req_data.operation;
               smp_in  = req_data.sample;
               keep_in = req_data.keep_count;
               state_in = S_PREP;
               case (req_data.operation)
                  OP_ADD: begin
                     if (at_len) begin
                        state_in = S_READ;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        sum_in   = sum_ff + req_ext;
                     end
                  end
                  OP_CLEAR: begin
                     oldest_in = '0;
                     count_in  = '0;
                     sum_in    = '0;
                  end
                  OP_TRIM: begin
                     if (CMP_BITS'(count_ff) > CMP_BITS'(req_data.keep_count)) begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_PREP;
                  end
               endcase
            end
         end
         S_READ: begin
            // Fetch the oldest sample; it lands in rd_data_ff next cycle
            state_in = S_SUB;
         end
         S_SUB: begin
            oldest_in = oldest_next;
            if (op_ff == OP_ADD) begin
               // Replace the oldest: read already done, so the write may hit the same slot
               mem_we   = 1'b1;
               mem_wd   = smp_ff;
               sum_in   = sum_ff - old_ext + smp_ext;
               state_in = S_PREP;
            end else begin
               count_in = count_dec;
               sum_in   = sum_ff - old_ext;
               if (CMP_BITS'(count_dec) > CMP_BITS'(keep_ff)) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            rem_in  = '0;
            step_in = '0;
            if (count_ff == '0) begin
               quo_in   = '0;
               neg_in   = 1'b0;
               state_in = S_PUT;
            end else begin
               neg_in   = sum_ff[SUM_BITS-1];
               quo_in   = sum_ff[SUM_BITS-1] ? (~sum_ff + SUM_BITS'(1)) : sum_ff;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (trial_ge) begin
               rem_in = CW'(trial - {1'b0, count_ff});
            end else begin
               rem_in = CW'(trial);
            end
            quo_in  = {quo_ff[SUM_BITS-2:0], trial_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_BITS - 1)) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            // Hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.window_sum    = sum_ff;
               rsp_data_in.window_mean   = neg_ff ? MEAN_BITS'(~quo_ff + SUM_BITS'(1))
                                                  : MEAN_BITS'(quo_ff);
               rsp_data_in.sample_count  = COUNT_OUT_BITS'(count_ff);
               rsp_data_in.window_full   = (count_ff == len);
               rsp_data_in.window_empty  = (count_ff == '0);
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register write clears the window
      if (csr_we) begin
         wlen_in   = csr_wdata;
         oldest_in = '0;
         count_in  = '0;
         sum_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         wlen_ff      <= LEN_BITS'(WINDOW_LEN_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         wlen_ff      <= wlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      smp_ff      <= smp_in;
      keep_ff     <= keep_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= store_mem[mem_ra];
   end

endmodule
